// File: design/utf8c_pkg.sv
// ----------------------------------------------------------------------------
// utf8c_pkg: shared types and constants of the utf-8 text classifier
// Class codes, lead byte masks and the overlong check masks.
// ----------------------------------------------------------------------------
package utf8c_pkg;

	// class of a finished text
	typedef enum logic [1:0] {
		CLASS_ASCII = 2'd0,
		CLASS_UTF8  = 2'd1,
		CLASS_8BIT  = 2'd2
	} text_class_t;

	// continuation byte test
	localparam logic [7:0] HIGH_BIT      = 8'h80;
	localparam logic [7:0] CONT_MASK     = 8'hC0;
	localparam logic [7:0] CONT_CODE     = 8'h80;
	// two byte lead payload bits that must not all be zero
	localparam logic [7:0] LEAD2_PAYLOAD = 8'h1E;

	// payload bits of longer leads
	localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
	localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;
	localparam logic [7:0] LEAD5_PAYLOAD = 8'h03;
	localparam logic [7:0] LEAD6_PAYLOAD = 8'h01;

	// bits of the following byte that rescue a zero-payload lead
	localparam logic [7:0] NEXT3_MASK    = 8'h20;
	localparam logic [7:0] NEXT4_MASK    = 8'h30;
	localparam logic [7:0] NEXT5_MASK    = 8'h38;
	localparam logic [7:0] NEXT6_MASK    = 8'h3C;

endpackage

// File: design/utf8c_text_if.sv
// ----------------------------------------------------------------------------
// utf8c_text_if: text byte channel
// Valid/ready channel carrying one byte of text and its end marks.
// ----------------------------------------------------------------------------
interface utf8c_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       no_byte;

	modport source (output valid, output data_byte, output last_byte, output no_byte,
		input ready);
	modport sink (input valid, input data_byte, input last_byte, input no_byte,
		output ready);
endinterface

// File: design/utf8c_class_if.sv
// ----------------------------------------------------------------------------
// utf8c_class_if: text class channel
// Valid/ready channel carrying the class of one finished text.
// ----------------------------------------------------------------------------
interface utf8c_class_if;
	logic       valid;
	logic       ready;
	logic [1:0] text_class;

	modport source (output valid, output text_class, input ready);
	modport sink (input valid, input text_class, output ready);
endinterface

// File: design/utf8_text_encoding_classifier.sv
// ----------------------------------------------------------------------------
// utf8_text_encoding_classifier: ascii / utf-8 / 8-bit text classifier
// Follows utf-8 sequences byte by byte (leads of up to six bytes) and gives
// one class per text on its last request.
// ----------------------------------------------------------------------------
//  channel  direction  payload                          request
//  text     sink       data_byte, last_byte, no_byte    one byte of text
//  result   source     text_class                       one per finished text
//
//  One byte per cycle while no earlier class blocks a last byte; a class passes
//  the input register, then the state update into the result register.
//  arst_n clears the input stage valid, the sequence state and the result valid.
//  A stalled result holds only a last byte in the input register; other bytes
//  keep flowing, so text input stops only while a second class waits.
// ----------------------------------------------------------------------------
module utf8_text_encoding_classifier
	import utf8c_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	utf8c_text_if.sink    text,
	utf8c_class_if.source result
);

	// input register
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       last_byte_s1;
	logic       no_byte_s1;

	// sequence state
	logic [2:0] pending_q;
	logic [7:0] mask_q;
	logic       high_q;
	logic       failed_q;

	// result register
	logic        out_valid_q;
	text_class_t class_q;

	// next state
	logic [2:0]  pending_n;
	logic [7:0]  mask_n;
	logic        high_n;
	logic        failed_n;
	text_class_t class_n;

	logic advance;

	// the stage moves on unless it holds a last byte and the result is blocked
	assign advance    = valid_s1 && (!last_byte_s1 || !out_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			data_byte_s1 <= text.data_byte;
			last_byte_s1 <= text.last_byte;
			no_byte_s1   <= text.no_byte;
		end
	end

	// byte decode and end of text handling
	always_comb begin
		logic [2:0] lead_len;
		logic [7:0] lead_pay;
		logic [7:0] next_mask;
		logic       fail_end;

		pending_n = pending_q;
		mask_n    = mask_q;
		high_n    = high_q;
		failed_n  = failed_q;
		lead_len  = 3'd0;
		lead_pay  = '0;
		next_mask = '0;

		// sequence length, payload bits and follow-up mask of a lead
		priority if (data_byte_s1 < 8'hC0) begin
			lead_len = 3'd0;
		end else if (data_byte_s1 < 8'hE0) begin
			lead_len = 3'd2;
			lead_pay = LEAD2_PAYLOAD;
		end else if (data_byte_s1 < 8'hF0) begin
			lead_len  = 3'd3;
			lead_pay  = LEAD3_PAYLOAD;
			next_mask = NEXT3_MASK;
		end else if (data_byte_s1 < 8'hF8) begin
			lead_len  = 3'd4;
			lead_pay  = LEAD4_PAYLOAD;
			next_mask = NEXT4_MASK;
		end else if (data_byte_s1 < 8'hFC) begin
			lead_len  = 3'd5;
			lead_pay  = LEAD5_PAYLOAD;
			next_mask = NEXT5_MASK;
		end else if (data_byte_s1 < 8'hFE) begin
			lead_len  = 3'd6;
			lead_pay  = LEAD6_PAYLOAD;
			next_mask = NEXT6_MASK;
		end else begin
			lead_len = 3'd0;
		end

		// state update for a byte
		if (!no_byte_s1 && !failed_q) begin
			if (pending_q != 3'd0) begin
				// continuation byte
				if ((data_byte_s1 & CONT_MASK) != CONT_CODE) begin
					failed_n = 1'b1;
				end
				if (mask_q != 8'h00 && (data_byte_s1 & mask_q) == 8'h00) begin
					failed_n = 1'b1;
				end
				mask_n    = 8'h00;
				pending_n = pending_q - 3'd1;
			end else if ((data_byte_s1 & HIGH_BIT) != 8'h00) begin
				high_n = 1'b1;
				if (lead_len == 3'd0) begin
					failed_n = 1'b1;
				end else begin
					pending_n = lead_len - 3'd1;
					mask_n    = 8'h00;
					if (lead_len == 3'd2) begin
						if ((data_byte_s1 & lead_pay) == 8'h00) begin
							failed_n = 1'b1;
						end
					end else if ((data_byte_s1 & lead_pay) == 8'h00) begin
						mask_n = next_mask;
					end
				end
			end
		end

		// class of the text, open sequence counts as cut off
		fail_end = failed_n || (pending_n != 3'd0);
		priority if (fail_end) begin
			class_n = CLASS_8BIT;
		end else if (high_n) begin
			class_n = CLASS_UTF8;
		end else begin
			class_n = CLASS_ASCII;
		end

		// last byte starts a new text
		if (last_byte_s1) begin
			pending_n = 3'd0;
			mask_n    = 8'h00;
			high_n    = 1'b0;
			failed_n  = 1'b0;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
			mask_q    <= 8'h00;
			high_q    <= 1'b0;
			failed_q  <= 1'b0;
		end else if (advance) begin
			pending_q <= pending_n;
			mask_q    <= mask_n;
			high_q    <= high_n;
			failed_q  <= failed_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_byte_s1) begin
			class_q <= class_n;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.text_class = class_q;

endmodule
